[rtl/core/rlsa_pkg.sv]
// Package for the run-length smoothing filter.
// Holds the widths, codes and structs shared by the front, the command queue,
// the back end and the top level. Depends on nothing.
package rlsa_pkg;

  localparam int unsigned PIX_W     = 8;
  localparam int unsigned THR_W     = 6;
  localparam int unsigned GAP_AW    = 6;
  localparam int unsigned GAP_DEPTH = 64;
  localparam int unsigned PTR_W     = GAP_AW + 1;
  localparam int unsigned CMD_DEPTH = 4;
  localparam int unsigned CMD_AW    = 2;
  localparam int unsigned ADDR_W    = 3;

  localparam logic [PIX_W-1:0]  WHITE_VALUE = 8'hFF;
  localparam logic [ADDR_W-1:0] REG_GAP_THR = 3'd0;

  // One command per input word that produces results: flush `count` held
  // pixels (filled or unchanged), then emit `pix` as the last word of the burst.
  typedef struct packed {
    logic [GAP_AW-1:0] count;
    logic              fill;
    logic [PIX_W-1:0]  pix;
    logic              line_end;
  } cmd_t;

  typedef struct packed {
    logic              en;
    logic [GAP_AW-1:0] addr;
    logic [PIX_W-1:0]  data;
  } gap_wr_t;

  typedef struct packed {
    logic              white_seen;
    logic              overflowed;
    logic [GAP_AW-1:0] gap_len;
    logic [PTR_W-1:0]  wr_ptr;
  } front_stat_t;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             line_end;
    logic             last_of_burst;
  } out_word_t;

endpackage

[rtl/core/rlsa_front.sv]
// Front end of the run-length smoothing filter: classifies each input word,
// keeps the line state, stores held pixels and issues flush commands.
// Depends on rlsa_pkg.
module rlsa_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [rlsa_pkg::PIX_W-1:0]         in_pix_i,
  input  logic                               in_line_end_i,
  input  logic [rlsa_pkg::THR_W-1:0]         thr_i,
  input  logic [rlsa_pkg::PTR_W-1:0]         gap_rd_ptr_i,
  input  logic                               cmd_full_i,
  output logic                               cmd_push_o,
  output rlsa_pkg::cmd_t                     cmd_o,
  output rlsa_pkg::gap_wr_t                  gap_wr_o,
  output rlsa_pkg::front_stat_t              stat_o
);

  logic                        white_seen_q, white_seen_d;
  logic                        overflowed_q, overflowed_d;
  logic [rlsa_pkg::GAP_AW-1:0] gap_len_q, gap_len_d;
  logic [rlsa_pkg::PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [rlsa_pkg::PTR_W-1:0]  gap_occ;
  logic                        gap_full;
  logic                        accept;
  logic                        is_white;
  logic                        fits;

  assign gap_occ    = wr_ptr_q - gap_rd_ptr_i;
  assign gap_full   = (gap_occ == rlsa_pkg::PTR_W'(rlsa_pkg::GAP_DEPTH));
  assign in_ready_o = !cmd_full_i && !gap_full;
  assign accept     = in_valid_i && in_ready_o;
  assign is_white   = (in_pix_i == rlsa_pkg::WHITE_VALUE);
  assign fits       = ({1'b0, gap_len_q} + 7'd1) <= {1'b0, thr_i};

  always_comb begin
    white_seen_d   = white_seen_q;
    overflowed_d   = overflowed_q;
    gap_len_d      = gap_len_q;
    wr_ptr_d       = wr_ptr_q;
    cmd_push_o     = 1'b0;
    cmd_o.count    = '0;
    cmd_o.fill     = 1'b0;
    cmd_o.pix      = in_pix_i;
    cmd_o.line_end = in_line_end_i;
    gap_wr_o.en    = 1'b0;
    gap_wr_o.addr  = wr_ptr_q[rlsa_pkg::GAP_AW-1:0];
    gap_wr_o.data  = in_pix_i;
    if (accept) begin
      if (is_white) begin
        cmd_push_o   = 1'b1;
        cmd_o.count  = gap_len_q;
        cmd_o.fill   = white_seen_q && !overflowed_q && ({1'b0, gap_len_q} <= {1'b0, thr_i});
        gap_len_d    = '0;
        white_seen_d = 1'b1;
        overflowed_d = 1'b0;
      end else if (!white_seen_q || overflowed_q) begin
        cmd_push_o = 1'b1;
      end else if (!fits) begin
        // The gap has outgrown the threshold: release it unchanged.
        cmd_push_o   = 1'b1;
        cmd_o.count  = gap_len_q;
        gap_len_d    = '0;
        overflowed_d = 1'b1;
      end else if (in_line_end_i) begin
        // The current pixel goes out behind the held ones, so it is not stored.
        cmd_push_o  = 1'b1;
        cmd_o.count = gap_len_q;
      end else begin
        gap_wr_o.en = 1'b1;
        wr_ptr_d    = wr_ptr_q + 7'd1;
        gap_len_d   = gap_len_q + 6'd1;
      end
      if (in_line_end_i) begin
        white_seen_d = 1'b0;
        overflowed_d = 1'b0;
        gap_len_d    = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      white_seen_q <= 1'b0;
      overflowed_q <= 1'b0;
      gap_len_q    <= '0;
      wr_ptr_q     <= '0;
    end else begin
      white_seen_q <= white_seen_d;
      overflowed_q <= overflowed_d;
      gap_len_q    <= gap_len_d;
      wr_ptr_q     <= wr_ptr_d;
    end
  end

  assign stat_o.white_seen = white_seen_q;
  assign stat_o.overflowed = overflowed_q;
  assign stat_o.gap_len    = gap_len_q;
  assign stat_o.wr_ptr     = wr_ptr_q;

endmodule

[rtl/core/rlsa_cmd_fifo.sv]
// Short command queue between the front and the back end of the filter.
// Depends on rlsa_pkg.
module rlsa_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rlsa_pkg::cmd_t push_data_i,
  input  logic           pop_i,
  output rlsa_pkg::cmd_t head_o,
  output logic           empty_o,
  output logic           full_o
);

  rlsa_pkg::cmd_t              mem_q [rlsa_pkg::CMD_DEPTH];
  logic [rlsa_pkg::CMD_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [rlsa_pkg::CMD_AW:0]   count_q, count_d;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == (rlsa_pkg::CMD_AW+1)'(rlsa_pkg::CMD_DEPTH));
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 3'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 2'd1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 2'd1;
      end
    end
  end

endmodule

[rtl/core/rlsa_back.sv]
// Back end of the filter: holds the gap store, executes flush commands one
// word per cycle while the output side has room, and drives the output
// through a two-entry queue. Depends on rlsa_pkg.
module rlsa_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rlsa_pkg::gap_wr_t           gap_wr_i,
  output logic [rlsa_pkg::PTR_W-1:0]  gap_rd_ptr_o,
  input  rlsa_pkg::cmd_t              cmd_i,
  input  logic                        cmd_empty_i,
  output logic                        cmd_pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output rlsa_pkg::out_word_t         out_o
);

  logic [rlsa_pkg::PIX_W-1:0]  gap_mem [rlsa_pkg::GAP_DEPTH];
  logic [rlsa_pkg::PIX_W-1:0]  rdata_q;
  logic [rlsa_pkg::PTR_W-1:0]  rd_ptr_q;
  logic [rlsa_pkg::GAP_AW-1:0] idx_q;

  // Read stage: one word in flight toward the output queue.
  logic                        infl_q;
  logic                        b_use_mem_q;
  logic                        b_fill_q;
  logic [rlsa_pkg::PIX_W-1:0]  b_pix_q;
  logic                        b_le_q;
  logic                        b_last_q;

  rlsa_pkg::out_word_t         oq_q [2];
  logic                        oq_head_q, oq_tail_q;
  logic [1:0]                  oq_cnt_q;

  logic [1:0]                  used;
  logic                        pop_out;
  logic                        room;
  logic                        issue;
  logic                        issue_mem;
  rlsa_pkg::out_word_t         b_word;

  assign pop_out   = out_valid_o && out_ready_i;
  assign used      = oq_cnt_q + {1'b0, infl_q};
  assign room      = (used < 2'd2) || (used == 2'd2 && pop_out);
  assign issue     = !cmd_empty_i && room;
  assign issue_mem = issue && (idx_q < cmd_i.count);
  assign cmd_pop_o = issue && !issue_mem;

  always_ff @(posedge clk_i) begin
    if (gap_wr_i.en) begin
      gap_mem[gap_wr_i.addr] <= gap_wr_i.data;
    end
    if (issue_mem) begin
      rdata_q <= gap_mem[rd_ptr_q[rlsa_pkg::GAP_AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      b_use_mem_q <= issue_mem;
      b_fill_q    <= issue_mem && cmd_i.fill;
      b_pix_q     <= cmd_i.pix;
      b_le_q      <= !issue_mem && cmd_i.line_end;
      b_last_q    <= !issue_mem;
    end
  end

  always_comb begin
    if (b_fill_q) begin
      b_word.pix = rlsa_pkg::WHITE_VALUE;
    end else if (b_use_mem_q) begin
      b_word.pix = rdata_q;
    end else begin
      b_word.pix = b_pix_q;
    end
    b_word.line_end      = b_le_q;
    b_word.last_of_burst = b_last_q;
  end

  always_ff @(posedge clk_i) begin
    if (infl_q) begin
      oq_q[oq_tail_q] <= b_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q  <= '0;
      idx_q     <= '0;
      infl_q    <= 1'b0;
      oq_head_q <= 1'b0;
      oq_tail_q <= 1'b0;
      oq_cnt_q  <= '0;
    end else begin
      infl_q <= issue;
      if (issue_mem) begin
        rd_ptr_q <= rd_ptr_q + 7'd1;
        idx_q    <= idx_q + 6'd1;
      end else if (cmd_pop_o) begin
        idx_q <= '0;
      end
      if (infl_q) begin
        oq_tail_q <= !oq_tail_q;
      end
      if (pop_out) begin
        oq_head_q <= !oq_head_q;
      end
      if (infl_q && !pop_out) begin
        oq_cnt_q <= oq_cnt_q + 2'd1;
      end else if (pop_out && !infl_q) begin
        oq_cnt_q <= oq_cnt_q - 2'd1;
      end
    end
  end

  assign out_valid_o  = (oq_cnt_q != '0);
  assign out_o        = oq_q[oq_head_q];
  assign gap_rd_ptr_o = rd_ptr_q;

endmodule

[rtl/core/run_length_smoothing_filter.sv]
// Top level of the run-length smoothing filter (RLSA) on a pixel stream.
// Depends on rlsa_pkg, rlsa_front, rlsa_cmd_fifo and rlsa_back.
//
//   channel   | direction | signals                         | words
//   ----------+-----------+---------------------------------+------------------------
//   s_axis    | in        | tvalid tready tdata tlast       | pixel, line end
//   m_axis    | out       | tvalid tready tdata tlast tuser | pixel, line end, burst end
//   apb       | in / out  | psel penable pwrite paddr ...   | gap threshold at 0x0
//
// The front takes one input word per cycle; the back end emits one output word
// per cycle while the output is ready. The front stalls only when the
// four-entry command queue or the 64-entry gap store is full. Reset is
// asynchronous and clears control state at once; the gap store is not
// cleared. Either side may stall without loss.
module run_length_smoothing_filter (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,  // [7:0] pixel_value
  input  logic                         s_axis_tlast,  // line_end
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [7:0]                   m_axis_tdata,  // [7:0] out_pixel
  output logic                         m_axis_tlast,  // out_line_end
  output logic                         m_axis_tuser,  // [0] last_of_burst
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rlsa_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  logic [rlsa_pkg::THR_W-1:0] thr_q;
  logic [rlsa_pkg::PTR_W-1:0] gap_rd_ptr;
  logic [rlsa_pkg::PTR_W-1:0] gap_occ;
  logic                       cmd_full, cmd_empty, cmd_push, cmd_pop;
  rlsa_pkg::cmd_t             cmd_in, cmd_head;
  rlsa_pkg::gap_wr_t          gap_wr;
  rlsa_pkg::front_stat_t      fstat;
  rlsa_pkg::out_word_t        out_word;

  assign pready = 1'b1;
  assign prdata = (paddr == rlsa_pkg::REG_GAP_THR) ? {26'b0, thr_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (psel && penable && pwrite && pready && paddr == rlsa_pkg::REG_GAP_THR) begin
      thr_q <= pwdata[rlsa_pkg::THR_W-1:0];
    end
  end

  rlsa_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_pix_i      (s_axis_tdata),
    .in_line_end_i (s_axis_tlast),
    .thr_i         (thr_q),
    .gap_rd_ptr_i  (gap_rd_ptr),
    .cmd_full_i    (cmd_full),
    .cmd_push_o    (cmd_push),
    .cmd_o         (cmd_in),
    .gap_wr_o      (gap_wr),
    .stat_o        (fstat)
  );

  rlsa_cmd_fifo u_cmd_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (cmd_push),
    .push_data_i (cmd_in),
    .pop_i       (cmd_pop),
    .head_o      (cmd_head),
    .empty_o     (cmd_empty),
    .full_o      (cmd_full)
  );

  rlsa_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .gap_wr_i     (gap_wr),
    .gap_rd_ptr_o (gap_rd_ptr),
    .cmd_i        (cmd_head),
    .cmd_empty_i  (cmd_empty),
    .cmd_pop_o    (cmd_pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_o        (out_word)
  );

  assign m_axis_tdata = out_word.pix;
  assign m_axis_tlast = out_word.line_end;
  assign m_axis_tuser = out_word.last_of_burst;

  assign gap_occ = fstat.wr_ptr - gap_rd_ptr;

  // A line always ends on the last word of a burst.
  a_line_end_closes_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
    else $error("line end without end of burst");

  a_line_state_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> fstat.gap_len == '0 && !fstat.white_seen)
    else $error("line state not cleared after line end");

  a_overflow_holds_nothing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fstat.overflowed |-> fstat.gap_len == '0 && fstat.white_seen)
    else $error("pixels held during an overflowed gap");

  a_gap_store_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gap_occ <= rlsa_pkg::PTR_W'(rlsa_pkg::GAP_DEPTH))
    else $error("gap store overrun");

endmodule

[bench/tb_top.sv]
// Self-checking bench for run_length_smoothing_filter: streams pixel lines with random
// stalls on both sides and checks every output word against a built-in gap-fill predictor.
// Depends on rlsa_pkg and the run_length_smoothing_filter RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 8;

  // Tracks the line state of the filter and the output words still owed.
  class smoothing_tracker;
    logic [rlsa_pkg::PIX_W-1:0] gap_pix [rlsa_pkg::GAP_DEPTH];
    int                         gap_len;
    bit                         white_seen;
    bit                         gap_over;
    int                         gap_thr;
    rlsa_pkg::out_word_t        due_pixels [$];
    int                         errors;

    function void flush_gap(ref rlsa_pkg::out_word_t burst [$], input bit fill);
      for (int i = 0; i < gap_len; i++) begin
        burst.push_back('{pix: fill ? rlsa_pkg::WHITE_VALUE : gap_pix[i], line_end: 1'b0,
                          last_of_burst: 1'b0});
      end
      gap_len = 0;
    endfunction

    function void take_pixel(logic [rlsa_pkg::PIX_W-1:0] pix, logic last);
      rlsa_pkg::out_word_t burst [$];
      bit                  fill;
      if (pix == rlsa_pkg::WHITE_VALUE) begin
        fill = white_seen && !gap_over && gap_len <= gap_thr;
        flush_gap(burst, fill);
        burst.push_back('{pix: pix, line_end: 1'b0, last_of_burst: 1'b0});
        white_seen = 1'b1;
        gap_over = 1'b0;
      end else if (!white_seen || gap_over) begin
        burst.push_back('{pix: pix, line_end: 1'b0, last_of_burst: 1'b0});
      end else if (gap_len + 1 > gap_thr) begin
        flush_gap(burst, 1'b0);
        burst.push_back('{pix: pix, line_end: 1'b0, last_of_burst: 1'b0});
        gap_over = 1'b1;
      end else begin
        gap_pix[gap_len] = pix;
        gap_len++;
      end
      if (last) begin
        flush_gap(burst, 1'b0);
        white_seen = 1'b0;
        gap_over = 1'b0;
        if (burst.size() > 0) burst[burst.size()-1].line_end = 1'b1;
      end
      if (burst.size() > 0) burst[burst.size()-1].last_of_burst = 1'b1;
      foreach (burst[i]) due_pixels.push_back(burst[i]);
    endfunction

    function void match_pixel(logic [rlsa_pkg::PIX_W-1:0] pix, logic lend, logic lob);
      rlsa_pkg::out_word_t want;
      if (due_pixels.size() == 0) begin
        $display("%0t: unexpected word pix=%0d line_end=%0b burst_end=%0b",
                 $time, pix, lend, lob);
        errors++;
        return;
      end
      want = due_pixels.pop_front();
      if (pix !== want.pix) begin
        $display("%0t: pixel expected %0d actual %0d", $time, want.pix, pix);
        errors++;
      end
      if (lend !== want.line_end) begin
        $display("%0t: line end expected %0b actual %0b", $time, want.line_end, lend);
        errors++;
      end
      if (lob !== want.last_of_burst) begin
        $display("%0t: burst end expected %0b actual %0b", $time, want.last_of_burst, lob);
        errors++;
      end
    endfunction
  endclass

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        s_axis_tvalid = 1'b0;
  logic                        s_axis_tready;
  logic [7:0]                  s_axis_tdata = '0;
  logic                        s_axis_tlast = 1'b0;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready = 1'b0;
  logic [7:0]                  m_axis_tdata;
  logic                        m_axis_tlast;
  logic                        m_axis_tuser;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [rlsa_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0]                 pwdata = '0;
  logic [31:0]                 prdata;
  logic                        pready;

  smoothing_tracker sb = new();
  int               sent_pixels = 0;
  int               sink_hold = 0;
  int               cycle_cnt = 0;
  bit               calm = 1'b0;

  run_length_smoothing_filter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Input words are noted before output words so a same-edge result finds its expectation.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.take_pixel(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        sb.match_pixel(m_axis_tdata, m_axis_tlast, m_axis_tuser);
        sink_hold = calm ? 0 : $urandom_range(0, 7);
      end
    end
  end

  always @(negedge clk_i) begin
    if (sink_hold > 0) begin
      m_axis_tready <= 1'b0;
      sink_hold = sink_hold - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("run_length_smoothing_filter: mismatch");
    $finish;
  end

  task automatic send_pixel(logic [7:0] pix, logic last);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 7);
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent_pixels++;
  endtask

  task automatic send_line(logic [7:0] line [$]);
    foreach (line[i]) send_pixel(line[i], i == line.size() - 1);
  endtask

  // Stops the sender and waits until every owed word has come out.
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.due_pixels.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_threshold(int value);
    drain();
    @(negedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= rlsa_pkg::REG_GAP_THR;
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== 32'(value)) begin
      $display("%0t: threshold read expected %0d actual %0d", $time, value, prdata);
      sb.errors++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.gap_thr = value;
  endtask

  function automatic logic [7:0] dark_pixel();
    return 8'($urandom_range(0, 254));
  endfunction

  // Mostly well-formed lines with gaps placed around the threshold; the rest is noise.
  task automatic random_line(int thr);
    logic [7:0] line [$];
    int         glen;
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 12)) begin
        line.push_back(($urandom_range(0, 3) == 0) ? rlsa_pkg::WHITE_VALUE
                                                   : 8'($urandom_range(0, 255)));
      end
    end else begin
      repeat ($urandom_range(0, 3)) line.push_back(dark_pixel());
      repeat ($urandom_range(1, 4)) begin
        repeat ($urandom_range(1, 2)) line.push_back(rlsa_pkg::WHITE_VALUE);
        case ($urandom_range(0, 3))
          0: glen = thr;
          1: glen = thr + 1;
          2: glen = (thr > 0) ? thr - 1 : 0;
          default: glen = $urandom_range(0, 2 * thr + 2);
        endcase
        repeat (glen) line.push_back(dark_pixel());
      end
      if ($urandom_range(0, 1) == 1) line.push_back(rlsa_pkg::WHITE_VALUE);
    end
    send_line(line);
  endtask

  task automatic random_phase(int thr, int budget);
    int start;
    set_threshold(thr);
    start = sent_pixels;
    while (sent_pixels - start < budget) begin
      calm = ($urandom_range(0, 5) == 0);
      random_line(thr);
      if ($urandom_range(0, 29) == 0) drain();
    end
    calm = 1'b0;
  endtask

  initial begin
    logic [7:0] line [$];
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    set_threshold(3);
    // Leading background, a gap at the threshold, an overflowing gap, whites back to back,
    // a white after an overflow and held pixels cut off by the line end.
    line = '{8'd0, 8'd17, rlsa_pkg::WHITE_VALUE, 8'd10, 8'd20, 8'd30, rlsa_pkg::WHITE_VALUE,
             8'd1, 8'd2, 8'd3, 8'd4, 8'd128, rlsa_pkg::WHITE_VALUE, rlsa_pkg::WHITE_VALUE,
             8'd254, 8'h55, 8'hAA};
    send_line(line);
    send_line('{rlsa_pkg::WHITE_VALUE});
    send_line('{rlsa_pkg::WHITE_VALUE, 8'd7});
    send_line('{8'd0});

    // Largest threshold: a 63-pixel gap is filled, one pixel longer overflows.
    set_threshold(63);
    line = '{rlsa_pkg::WHITE_VALUE};
    repeat (63) line.push_back(dark_pixel());
    line.push_back(rlsa_pkg::WHITE_VALUE);
    repeat (64) line.push_back(dark_pixel());
    line.push_back(rlsa_pkg::WHITE_VALUE);
    send_line(line);

    random_phase(0, 50);
    random_phase(1, 50);
    random_phase($urandom_range(2, 5), 55);
    random_phase($urandom_range(6, 12), 55);
    random_phase(2, 50);
    drain();

    if (sb.errors == 0 && sb.due_pixels.size() == 0) begin
      $display("run_length_smoothing_filter: match");
    end else begin
      $display("run_length_smoothing_filter: mismatch");
    end
    $finish;
  end

endmodule
